/* rtl/lpcmp_pkg.sv */
// Shared types, constants and small decode functions for the LPCM packetizer.
// Used by every module under rtl/; depends on nothing.
package lpcmp_pkg;

	localparam int GROUP_MAX    = 12;
	localparam int HDR_LEN      = 14;
	localparam int PES_OVERHEAD = 18;
	localparam int SUB_W        = 13;

	// register indexes of the configuration port
	localparam logic [1:0] REG_RATE     = 2'd0;
	localparam logic [1:0] REG_CHANNELS = 2'd1;
	localparam logic [1:0] REG_WIDE     = 2'd2;

	// private header constants
	localparam logic [7:0] HDR_SYNC    = 8'hA0;
	localparam logic [7:0] HDR_B3      = 8'h0A;
	localparam logic [7:0] HDR_B5      = 8'h09;
	localparam logic [7:0] HDR_QUANT   = 8'h0F;
	localparam logic [7:0] HDR_WIDE24  = 8'h20;
	localparam logic [7:0] HDR_B11     = 8'h80;

	localparam logic [7:0] BASE_LOW  = 8'd40;
	localparam logic [7:0] BASE_MID  = 8'd80;
	localparam logic [7:0] BASE_HIGH = 8'd160;

	typedef struct packed {
		logic [2:0] rate_code;
		logic [3:0] channel_count;
		logic       wide_samples;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{rate_code: 3'd0, channel_count: 4'd2, wide_samples: 1'b0};

	// one finished group, already reordered, plus its framing marks
	typedef struct packed {
		logic [GROUP_MAX-1:0][7:0] data;
		logic                      hdr;
		logic                      ends;
		logic [4:0]                cnt;
	} job_t;

	function automatic logic [7:0] sub_base(input logic [2:0] rate);
		logic [7:0] b;
		unique case (rate)
			3'd0, 3'd3: b = BASE_LOW;
			3'd1, 3'd4: b = BASE_MID;
			3'd2, 3'd5: b = BASE_HIGH;
			default:    b = 8'd0;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] rate_bits(input logic [2:0] rate);
		logic [7:0] b;
		unique case (rate)
			3'd1:    b = 8'h10;
			3'd2:    b = 8'h20;
			3'd3:    b = 8'h80;
			3'd4:    b = 8'h90;
			3'd5:    b = 8'hA0;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// source byte of each output slot for a 24-bit stereo group
	function automatic logic [3:0] perm_src(input logic [3:0] i);
		logic [3:0] s;
		unique case (i)
			4'd0:    s = 4'd2;
			4'd1:    s = 4'd1;
			4'd2:    s = 4'd5;
			4'd3:    s = 4'd4;
			4'd4:    s = 4'd8;
			4'd5:    s = 4'd7;
			4'd6:    s = 4'd11;
			4'd7:    s = 4'd10;
			4'd8:    s = 4'd0;
			4'd9:    s = 4'd3;
			4'd10:   s = 4'd6;
			4'd11:   s = 4'd9;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [3:0] i, input logic [4:0] cnt,
			input cfg_t cfg);
		logic [7:0] b;
		unique case (i)
			4'd0:    b = HDR_SYNC;
			4'd1:    b = {3'b000, cnt};
			4'd3:    b = HDR_B3;
			4'd5:    b = HDR_B5;
			4'd7:    b = HDR_QUANT | (cfg.wide_samples ? HDR_WIDE24 : 8'h00);
			4'd8:    b = HDR_QUANT | rate_bits(cfg.rate_code);
			4'd10:   b = {4'b0000, cfg.channel_count - 4'd1};
			4'd11:   b = HDR_B11;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* rtl/lpcmp_derive.sv */
// Configuration registers and payload length derivation (subframe size and
// a restoring divider, one quotient bit per cycle). Uses lpcmp_pkg.
module lpcmp_derive #(
	parameter int PACKET_SIZE = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [3:0]                     cfg_data,
	output lpcmp_pkg::cfg_t                cfg,
	output logic                           busy,
	output logic [$clog2(PACKET_SIZE)-1:0] payload_len,
	output logic [4:0]                     spp
);
	localparam int NW = $clog2(PACKET_SIZE);
	localparam int RW = lpcmp_pkg::SUB_W + 1;
	localparam int SW = $clog2(NW);
	localparam logic [NW-1:0] AVAIL =
		NW'(PACKET_SIZE - lpcmp_pkg::PES_OVERHEAD - lpcmp_pkg::HDR_LEN);

	typedef enum logic [1:0] {D_SUB, D_DIV, D_IDLE} state_t;

	state_t                      state_q;
	lpcmp_pkg::cfg_t             cfg_q;
	logic [lpcmp_pkg::SUB_W-1:0] sub_q;
	logic [lpcmp_pkg::SUB_W-1:0] rem_q;
	logic [NW-1:0]               num_q;
	logic [4:0]                  quo_q;
	logic [SW-1:0]               step_q;
	logic [NW-1:0]               payload_q;
	logic [4:0]                  spp_q;

	logic                        cfg_hit;
	logic [11:0]                 base_ch;
	logic [lpcmp_pkg::SUB_W-1:0] sub_comb;
	logic [RW-1:0]               shifted;
	logic [lpcmp_pkg::SUB_W-1:0] rem_next;
	logic [4:0]                  quo_next;

	assign cfg_hit = cfg_wr_en && ((cfg_index == lpcmp_pkg::REG_RATE) ||
		(cfg_index == lpcmp_pkg::REG_CHANNELS) || (cfg_index == lpcmp_pkg::REG_WIDE));

	always_comb begin
		base_ch  = 12'(lpcmp_pkg::sub_base(cfg_q.rate_code)) * 12'(cfg_q.channel_count);
		// bytes per sample: 2 or 3
		sub_comb = {base_ch, 1'b0} + (cfg_q.wide_samples ? {1'b0, base_ch} : '0);
		shifted  = {rem_q, num_q[NW-1]};
		if (shifted >= {1'b0, sub_q}) begin
			rem_next = lpcmp_pkg::SUB_W'(shifted - {1'b0, sub_q});
			quo_next = {quo_q[3:0], 1'b1};
		end else begin
			rem_next = lpcmp_pkg::SUB_W'(shifted);
			quo_next = {quo_q[3:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= D_SUB;
			cfg_q     <= lpcmp_pkg::CFG_RESET;
			payload_q <= '0;
			spp_q     <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				lpcmp_pkg::REG_RATE:     cfg_q.rate_code     <= cfg_data[2:0];
				lpcmp_pkg::REG_CHANNELS: cfg_q.channel_count <= cfg_data;
				lpcmp_pkg::REG_WIDE:     cfg_q.wide_samples  <= cfg_data[0];
				default: ;
			endcase
			state_q <= D_SUB;
		end else begin
			unique case (state_q)
				D_SUB: begin
					sub_q   <= sub_comb;
					rem_q   <= '0;
					num_q   <= AVAIL;
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= D_DIV;
				end
				D_DIV: begin
					if (sub_q == '0) begin
						// subframe size is zero: drop everything
						payload_q <= '0;
						spp_q     <= '0;
						state_q   <= D_IDLE;
					end else begin
						rem_q  <= rem_next;
						quo_q  <= quo_next;
						num_q  <= {num_q[NW-2:0], 1'b0};
						step_q <= step_q + SW'(1);
						if (step_q == SW'(NW - 1)) begin
							// payload = AVAIL - AVAIL mod sub
							payload_q <= AVAIL - NW'(rem_next);
							spp_q     <= quo_next;
							state_q   <= D_IDLE;
						end
					end
				end
				D_IDLE: ;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign cfg         = cfg_q;
	assign busy        = (state_q != D_IDLE);
	assign payload_len = payload_q;
	assign spp         = spp_q;

	a_payload_fits: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (payload_q <= AVAIL))
		else $error("derived payload length exceeds packet room");

endmodule

/* rtl/lpcmp_front.sv */
// Front end: accepts bytes, collects groups, tracks packet framing and
// emits one reordered group job per completed group. Uses lpcmp_pkg.
module lpcmp_front #(
	parameter int PACKET_SIZE = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  lpcmp_pkg::cfg_t                cfg,
	input  logic                           busy,
	input  logic [$clog2(PACKET_SIZE)-1:0] payload_len,
	input  logic [4:0]                     spp,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     sample_byte,
	input  logic                           q_full,
	output logic                           push,
	output lpcmp_pkg::job_t                push_job
);
	localparam int PW = $clog2(PACKET_SIZE);

	logic [7:0]  group_store_q [lpcmp_pkg::GROUP_MAX];
	logic [3:0]  group_fill_q;
	logic [PW-1:0] packet_fill_q;
	logic [4:0]  sf_count_q;

	logic        accept;
	logic        live;
	logic [3:0]  gsize_m1;
	logic        completing;
	logic        start_pkt;
	logic [4:0]  cnt_next;
	logic [PW:0] pf_sum;
	logic        ends;
	logic [7:0]  cur [lpcmp_pkg::GROUP_MAX];

	assign in_ready = !busy && !q_full;
	assign accept   = in_valid && in_ready;
	assign live     = (payload_len != '0);

	always_comb begin
		gsize_m1   = cfg.wide_samples ? 4'd11 : 4'd1;
		completing = (group_fill_q == gsize_m1);
		start_pkt  = (packet_fill_q == '0);
		cnt_next   = sf_count_q + spp;
		pf_sum     = {1'b0, packet_fill_q} + (PW+1)'(gsize_m1) + (PW+1)'(1);
		ends       = (pf_sum >= {1'b0, payload_len});
		for (int i = 0; i < lpcmp_pkg::GROUP_MAX; i++) begin
			cur[i] = (group_fill_q == 4'(i)) ? sample_byte : group_store_q[i];
		end
		for (int i = 0; i < lpcmp_pkg::GROUP_MAX; i++) begin
			push_job.data[i] = cfg.wide_samples ? cur[lpcmp_pkg::perm_src(4'(i))] : 8'h00;
		end
		if (!cfg.wide_samples) begin
			// 16-bit: swap to big-endian
			push_job.data[0] = cur[1];
			push_job.data[1] = cur[0];
		end
		push_job.hdr  = start_pkt;
		push_job.ends = ends;
		push_job.cnt  = start_pkt ? cnt_next : sf_count_q;
	end

	assign push = accept && live && completing;

	always_ff @(posedge clk) begin
		if (accept && live && !completing) begin
			group_store_q[group_fill_q] <= sample_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_fill_q  <= '0;
			packet_fill_q <= '0;
			sf_count_q    <= '0;
		end else if (clear) begin
			group_fill_q  <= '0;
			packet_fill_q <= '0;
			sf_count_q    <= '0;
		end else if (accept && live) begin
			if (completing) begin
				group_fill_q  <= '0;
				packet_fill_q <= ends ? '0 : PW'(pf_sum);
				if (start_pkt) begin
					sf_count_q <= cnt_next;
				end
			end else begin
				group_fill_q <= group_fill_q + 4'd1;
			end
		end
	end

endmodule

/* rtl/lpcmp_queue.sv */
// Two-entry job queue between the front end and the byte serializer.
// Uses lpcmp_pkg for the job type.
module lpcmp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lpcmp_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output lpcmp_pkg::job_t head,
	output logic            head_valid
);
	lpcmp_pkg::job_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2))
		else $error("job pushed into a full queue");

endmodule

/* rtl/lpcmp_back.sv */
// Back end: walks the head job byte by byte (header first when marked)
// into a registered output stage. Uses lpcmp_pkg.
module lpcmp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lpcmp_pkg::cfg_t cfg,
	input  lpcmp_pkg::job_t head,
	input  logic            head_valid,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            packet_start,
	output logic            packet_end,
	output logic            last
);
	logic [4:0] pos_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       start_q;
	logic       end_q;
	logic       last_q;

	logic [4:0] len_m1;
	logic       final_pos;
	logic       adv;
	logic       in_hdr;
	logic [4:0] di;
	logic [7:0] byte_sel;

	always_comb begin
		if (head.hdr) begin
			len_m1 = cfg.wide_samples ? 5'd25 : 5'd15;
			di     = pos_q - 5'(lpcmp_pkg::HDR_LEN);
		end else begin
			len_m1 = cfg.wide_samples ? 5'd11 : 5'd1;
			di     = pos_q;
		end
		in_hdr    = head.hdr && (pos_q < 5'(lpcmp_pkg::HDR_LEN));
		final_pos = (pos_q == len_m1);
		if (in_hdr) begin
			byte_sel = lpcmp_pkg::hdr_byte(pos_q[3:0], head.cnt, cfg);
		end else if (di < 5'(lpcmp_pkg::GROUP_MAX)) begin
			byte_sel = head.data[di[3:0]];
		end else begin
			byte_sel = 8'h00;
		end
	end

	assign adv = head_valid && (!out_valid_q || out_ready);
	assign pop = adv && final_pos;

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q  <= byte_sel;
			start_q <= head.hdr && (pos_q == 5'd0);
			end_q   <= head.ends && final_pos;
			last_q  <= final_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				pos_q       <= final_pos ? 5'd0 : pos_q + 5'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = byte_q;
	assign packet_start = start_q;
	assign packet_end   = end_q;
	assign last         = last_q;

	a_start_is_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && start_q) |-> (byte_q == lpcmp_pkg::HDR_SYNC))
		else $error("packet start without header sync byte");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_q) |-> last_q)
		else $error("packet end not on the last byte of a group");

endmodule

/* rtl/lpcm_packetizer_core.sv */
// LPCM packetizer top level: configuration, front end, job queue, serializer.
// Depends on lpcmp_pkg, lpcmp_derive, lpcmp_front, lpcmp_queue, lpcmp_back.
//
// Frames a little-endian PCM byte stream (one byte per item) as DVD LPCM
// packets: a 14-byte private header followed by reordered sample groups of
// 2 bytes (16-bit, byte-swapped) or 12 bytes (24-bit, permuted). The front
// end takes one input item per clock while the two-entry job queue has room
// and the divider is not busy; the serializer sends one output item per
// clock while out_ready is high, so a group is 2 or 12 output bytes, plus 14
// header bytes when it opens a packet. Each output item carries last on the
// final byte of the group that the input item completed, and packet_end on
// the final payload byte of a packet. After reset and after every write to a
// defined register the payload length is recomputed and framing restarts;
// in_ready stays low until the one-bit-per-cycle divider has finished.
// Write configuration only while no results are pending. When no whole
// subframe fits, input items are accepted and dropped.
module lpcm_packetizer_core #(
	parameter int PACKET_SIZE = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] sample_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       packet_start,
	output logic       packet_end,
	output logic       last
);
	localparam int PW = $clog2(PACKET_SIZE);

	lpcmp_pkg::cfg_t cfg;
	logic            busy;
	logic [PW-1:0]   payload_len;
	logic [4:0]      spp;
	logic            restart;
	logic            q_full;
	logic            push;
	lpcmp_pkg::job_t push_job;
	lpcmp_pkg::job_t head;
	logic            head_valid;
	logic            pop;

	// a write to a defined register restarts the framing
	assign restart = cfg_wr_en && ((cfg_index == lpcmp_pkg::REG_RATE) ||
		(cfg_index == lpcmp_pkg::REG_CHANNELS) || (cfg_index == lpcmp_pkg::REG_WIDE));

	lpcmp_derive #(.PACKET_SIZE(PACKET_SIZE)) u_derive (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg         (cfg),
		.busy        (busy),
		.payload_len (payload_len),
		.spp         (spp)
	);

	// front: collect groups, decide header and packet end
	lpcmp_front #(.PACKET_SIZE(PACKET_SIZE)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (restart),
		.cfg         (cfg),
		.busy        (busy),
		.payload_len (payload_len),
		.spp         (spp),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_byte (sample_byte),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	// hold finished groups so either side can stall on its own
	lpcmp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// back: serialize header and group bytes
	lpcmp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.packet_start (packet_start),
		.packet_end   (packet_end),
		.last         (last)
	);

endmodule
